// ===== rtl/core/rc4s_pkg.sv =====
`default_nettype none

package rc4s_pkg;

	localparam int STATE_SIZE_DEF = 256;
	localparam int DATA_W         = 8;
	localparam int KEY_W          = 64;
	localparam int KEY_LEN_W      = 4;
	localparam int KEY_POS_W      = 3;
	localparam int REG_IDX_W      = 2;

	localparam logic [REG_IDX_W-1:0] REG_KEY_BYTES  = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_KEY_LENGTH = 2'd1;

	localparam logic [KEY_LEN_W-1:0] KEY_LEN_RESET = 4'd8;
	localparam logic [KEY_LEN_W-1:0] KEY_LEN_MIN   = 4'd1;
	localparam logic [KEY_LEN_W-1:0] KEY_LEN_MAX   = 4'd8;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_FILL,
		ST_K_RD_I,
		ST_K_RD_J,
		ST_K_WR_I,
		ST_K_WR_J,
		ST_G_RD_I,
		ST_G_RD_J,
		ST_G_WR_I,
		ST_G_WR_J,
		ST_G_RD_T,
		ST_G_OUT
	} rc4s_state_t;

	typedef struct packed {
		logic [DATA_W-1:0] data;
		logic              start;
		logic              last;
	} rc4s_item_t;

endpackage

`default_nettype wire

// ===== rtl/core/rc4s_modadd.sv =====
`default_nettype none

module rc4s_modadd #(
	parameter int STATE_SIZE = rc4s_pkg::STATE_SIZE_DEF,
	parameter int IW         = $clog2(STATE_SIZE)
) (
	input  wire logic [IW-1:0] a,
	input  wire logic [IW-1:0] b,
	input  wire logic [IW-1:0] c,
	output logic      [IW-1:0] sum
);
	localparam logic [IW:0] MODULUS = (IW+1)'(STATE_SIZE);

	logic [IW:0]   sum_ab;
	logic [IW-1:0] red_ab;
	logic [IW:0]   sum_abc;

	// reduce after each add: operands stay below the modulus
	always_comb begin
		sum_ab  = {1'b0, a} + {1'b0, b};
		red_ab  = (sum_ab >= MODULUS) ? IW'(sum_ab - MODULUS) : IW'(sum_ab);
		sum_abc = {1'b0, red_ab} + {1'b0, c};
		sum     = (sum_abc >= MODULUS) ? IW'(sum_abc - MODULUS) : IW'(sum_abc);
	end

endmodule

`default_nettype wire

// ===== rtl/core/rc4_stream_cipher_core.sv =====
// RC4 stream cipher core.
// Input stream (s_axis_*): one data byte per transaction; tuser set rekeys the
// table before that byte, tlast is passed through to the result.
// Output stream (m_axis_*): one byte per input transaction, data XOR keystream.
// Config channel (cfg_*): index 0 writes the 64-bit key (byte zero low), index 1
// the key length (0 acts as 1, above 8 acts as 8). Always ready; write only while
// the core is idle. New values are used at the next rekey.
// Sequence: a byte without rekey reads S[i], reads S[j], writes both, reads the
// keystream byte and registers the result before the next accept. All work goes
// through one single-port-read permutation RAM and one modular adder, so each byte
// costs two table reads, two writes and a keystream read in sequence.
// A rekey first fills the table with the identity and then runs the key schedule,
// which reads S[i] and S[j] and writes both for every table entry.
// Reset: the core is unkeyed; the first byte after reset always rekeys. The key
// registers return to zero key and length 8.
// Stall: a result is held in the output register until taken; the core accepts
// the next byte meanwhile but holds its own result until the register is free.
`default_nettype none

module rc4_stream_cipher_core #(
	parameter int STATE_SIZE = rc4s_pkg::STATE_SIZE_DEF
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             s_axis_tvalid,
	output logic                                  s_axis_tready,
	input  wire logic [rc4s_pkg::DATA_W-1:0]      s_axis_tdata,  // [7:0] data_byte
	input  wire logic                             s_axis_tuser,  // [0] start_req
	input  wire logic                             s_axis_tlast,
	output logic                                  m_axis_tvalid,
	input  wire logic                             m_axis_tready,
	output logic      [rc4s_pkg::DATA_W-1:0]      m_axis_tdata,  // [7:0] out_byte
	output logic                                  m_axis_tlast,
	input  wire logic                             cfg_valid,
	output logic                                  cfg_ready,
	input  wire logic [rc4s_pkg::REG_IDX_W-1:0]   cfg_index,
	input  wire logic [rc4s_pkg::KEY_W-1:0]       cfg_data
);
	import rc4s_pkg::*;

	localparam int            IW       = $clog2(STATE_SIZE);
	localparam logic [IW-1:0] IDX_LAST = IW'(STATE_SIZE - 1);
	localparam logic [IW-1:0] IDX_ONE  = IW'(1);

	rc4s_state_t state_q, state_d;

	logic [KEY_W-1:0]     key_q;
	logic [KEY_LEN_W-1:0] klen_q;
	logic [KEY_LEN_W-1:0] klen_eff;
	logic [KEY_POS_W-1:0] kpos_q;
	logic [DATA_W-1:0]    key_byte;
	logic [IW-1:0]        kmod_tbl [256];

	rc4s_item_t item_q;
	logic       keyed_q;
	logic [IW-1:0] k_q, i_q, j_q, si_q, t_q;

	logic [IW-1:0] perm_mem [STATE_SIZE];
	logic [IW-1:0] rdata_q;
	logic          rd_en, wr_en;
	logic [IW-1:0] rd_addr, wr_addr, wr_data;

	logic [IW-1:0] op_a, op_b, op_c, add_sum;

	logic              m_valid_q;
	logic [DATA_W-1:0] m_data_q;
	logic              m_last_q;
	logic              out_free;

	for (genvar g = 0; g < 256; g++) begin : g_kmod
		assign kmod_tbl[g] = IW'(g % STATE_SIZE);
	end

	assign cfg_ready     = 1'b1;
	assign s_axis_tready = (state_q == ST_IDLE);
	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;
	assign m_axis_tlast  = m_last_q;
	assign out_free      = !m_valid_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q  <= '0;
			klen_q <= KEY_LEN_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_KEY_BYTES:  key_q  <= cfg_data;
				REG_KEY_LENGTH: klen_q <= cfg_data[KEY_LEN_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		klen_eff = klen_q;
		if (klen_q == '0)
			klen_eff = KEY_LEN_MIN;
		else if (klen_q inside {[4'd9:4'd15]})
			klen_eff = KEY_LEN_MAX;
		key_byte = key_q[{kpos_q, 3'b000} +: DATA_W];
	end

	rc4s_modadd #(
		.STATE_SIZE (STATE_SIZE),
		.IW         (IW)
	) u_modadd (
		.a   (op_a),
		.b   (op_b),
		.c   (op_c),
		.sum (add_sum)
	);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (s_axis_tvalid)
					state_d = (s_axis_tuser || !keyed_q) ? ST_FILL : ST_G_RD_I;
			end
			ST_FILL:   if (k_q == IDX_LAST) state_d = ST_K_RD_I;
			ST_K_RD_I: state_d = ST_K_RD_J;
			ST_K_RD_J: state_d = ST_K_WR_I;
			ST_K_WR_I: state_d = ST_K_WR_J;
			ST_K_WR_J: state_d = (k_q == IDX_LAST) ? ST_G_RD_I : ST_K_RD_I;
			ST_G_RD_I: state_d = ST_G_RD_J;
			ST_G_RD_J: state_d = ST_G_WR_I;
			ST_G_WR_I: state_d = ST_G_WR_J;
			ST_G_WR_J: state_d = ST_G_RD_T;
			ST_G_RD_T: state_d = ST_G_OUT;
			ST_G_OUT:  if (out_free) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		rd_en   = 1'b0;
		rd_addr = '0;
		wr_en   = 1'b0;
		wr_addr = '0;
		wr_data = '0;
		op_a    = '0;
		op_b    = '0;
		op_c    = '0;
		case (state_q)
			ST_FILL: begin
				wr_en   = 1'b1;
				wr_addr = k_q;
				wr_data = k_q;
			end
			ST_K_RD_I: begin
				rd_en   = 1'b1;
				rd_addr = k_q;
			end
			ST_K_RD_J: begin
				op_a    = j_q;
				op_b    = rdata_q;
				op_c    = kmod_tbl[key_byte];
				rd_en   = 1'b1;
				rd_addr = add_sum;
			end
			ST_K_WR_I: begin
				wr_en   = 1'b1;
				wr_addr = k_q;
				wr_data = rdata_q;
			end
			ST_K_WR_J: begin
				wr_en   = 1'b1;
				wr_addr = j_q;
				wr_data = si_q;
			end
			ST_G_RD_I: begin
				op_a    = i_q;
				op_b    = IDX_ONE;
				rd_en   = 1'b1;
				rd_addr = add_sum;
			end
			ST_G_RD_J: begin
				op_a    = j_q;
				op_b    = rdata_q;
				rd_en   = 1'b1;
				rd_addr = add_sum;
			end
			ST_G_WR_I: begin
				op_a    = si_q;
				op_b    = rdata_q;
				wr_en   = 1'b1;
				wr_addr = i_q;
				wr_data = rdata_q;
			end
			ST_G_WR_J: begin
				wr_en   = 1'b1;
				wr_addr = j_q;
				wr_data = si_q;
			end
			ST_G_RD_T: begin
				rd_en   = 1'b1;
				rd_addr = t_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en)
			perm_mem[wr_addr] <= wr_data;
		if (rd_en)
			rdata_q <= perm_mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			keyed_q <= 1'b0;
			k_q     <= '0;
			i_q     <= '0;
			j_q     <= '0;
			kpos_q  <= '0;
		end else begin
			state_q <= state_d;
			case (state_q)
				ST_IDLE: begin
					if (s_axis_tvalid && (s_axis_tuser || !keyed_q)) begin
						k_q    <= '0;
						j_q    <= '0;
						kpos_q <= '0;
					end
				end
				ST_FILL: k_q <= (k_q == IDX_LAST) ? '0 : k_q + IDX_ONE;
				ST_K_RD_J: j_q <= add_sum;
				ST_K_WR_J: begin
					kpos_q <= (kpos_q == KEY_POS_W'(klen_eff - 4'd1)) ? '0 : kpos_q + 3'd1;
					if (k_q == IDX_LAST) begin
						k_q     <= '0;
						i_q     <= '0;
						j_q     <= '0;
						keyed_q <= 1'b1;
					end else begin
						k_q <= k_q + IDX_ONE;
					end
				end
				ST_G_RD_I: i_q <= add_sum;
				ST_G_RD_J: j_q <= add_sum;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready)
			item_q <= '{data: s_axis_tdata, start: s_axis_tuser, last: s_axis_tlast};
		if (state_q == ST_K_RD_J || state_q == ST_G_RD_J)
			si_q <= rdata_q;
		if (state_q == ST_G_WR_I)
			t_q <= add_sum;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (state_q == ST_G_OUT && out_free) begin
			m_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_G_OUT && out_free) begin
			m_data_q <= item_q.data ^ DATA_W'(rdata_q);
			m_last_q <= item_q.last;
		end
	end

	a_keyed_holds: assert property (@(posedge clk) disable iff (!arst_n)
		keyed_q |=> keyed_q)
		else $error("keyed flag cleared outside reset");

	a_gen_needs_key: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_G_RD_I) |-> keyed_q)
		else $error("keystream generation started on an unkeyed table");

	a_result_from_out: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_valid_q) |-> $past(state_q == ST_G_OUT))
		else $error("result raised outside the output step");

	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		(i_q <= IDX_LAST) && (j_q <= IDX_LAST) && (k_q <= IDX_LAST))
		else $error("table index beyond table size");

endmodule

`default_nettype wire
